// ----- sv/htt_pkg.sv -----
// Shared types, character codes and token kinds for the HTML tag tokenizer.
package htt_pkg;

  localparam int OffsetBits = 16;
  localparam int FldW       = 16;
  localparam int MaxTok     = 3;

  typedef logic [OffsetBits-1:0] pos_t;
  typedef logic [OffsetBits:0]   pos_ext_t;

  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_QMARK = 8'd63;

  localparam logic [3:0] TK_TEXT     = 4'd0;
  localparam logic [3:0] TK_TAG      = 4'd1;
  localparam logic [3:0] TK_MARK     = 4'd2;
  localparam logic [3:0] TK_SELF     = 4'd3;
  localparam logic [3:0] TK_END_TAG  = 4'd4;
  localparam logic [3:0] TK_ANAME    = 4'd5;
  localparam logic [3:0] TK_AVAL     = 4'd6;
  localparam logic [3:0] TK_COMMENT  = 4'd7;
  localparam logic [3:0] TK_UNSUP    = 4'd8;

  typedef enum logic [17:0] {
    ST_DATA         = 18'h00001,
    ST_TAG_OPEN     = 18'h00002,
    ST_END_TAG_OPEN = 18'h00004,
    ST_TAG_NAME     = 18'h00008,
    ST_END_TAG_SKIP = 18'h00010,
    ST_BEFORE_ANAME = 18'h00020,
    ST_ANAME        = 18'h00040,
    ST_AFTER_ANAME  = 18'h00080,
    ST_BEFORE_VAL   = 18'h00100,
    ST_VAL_Q        = 18'h00200,
    ST_VAL_UNQ      = 18'h00400,
    ST_AFTER_VAL_Q  = 18'h00800,
    ST_SELF_CLOSE   = 18'h01000,
    ST_MARKUP_OPEN  = 18'h02000,
    ST_MARKUP_DASH  = 18'h04000,
    ST_COMMENT      = 18'h08000,
    ST_BOGUS        = 18'h10000,
    ST_UNSUP        = 18'h20000
  } tk_state_t;

  typedef struct packed {
    tk_state_t   st;
    pos_t        pos;
    pos_t        tb;
    logic        closing;
    logic        quote;
    logic [15:0] la;
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic [3:0]      kind;
    logic [FldW-1:0] offset;
    logic [FldW-1:0] length;
  } tok_t;

  typedef struct packed {
    logic [1:0]             count;
    tok_t [MaxTok-1:0]      tok;
  } bundle_t;

  typedef struct packed {
    logic [3:0]      token_kind;
    logic [FldW-1:0] token_offset;
    logic [FldW-1:0] token_length;
    logic            last_of_run;
  } token_t;

endpackage

// ----- sv/htt_step.sv -----
// Next-state and token logic for one document byte.
module htt_step (
  input  htt_pkg::state_t  cur,
  input  htt_pkg::item_t   item,
  output htt_pkg::state_t  nxt,
  output htt_pkg::bundle_t bundle
);
  import htt_pkg::*;

  localparam logic [63:0] FldMax = 64'((65'd1 << FldW) - 65'd1);

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction

  function automatic logic [FldW-1:0] span_len(pos_ext_t end_p, pos_t b);
    pos_ext_t diff;
    diff = end_p - {1'b0, b};
    if (end_p <= {1'b0, b}) begin
      return '0;
    end
    if (64'(diff) > FldMax) begin
      return FldW'(FldMax);
    end
    return FldW'(diff);
  endfunction

  function automatic tok_t mk(logic [3:0] k, pos_t off, logic [FldW-1:0] len);
    tok_t t;
    t.kind   = k;
    t.offset = FldW'(off);
    t.length = len;
    return t;
  endfunction

  logic [7:0] c;
  logic       eoi;
  pos_t       p;
  pos_t       tb;
  pos_t       pn;
  pos_ext_t   p_ext;
  pos_ext_t   p1_ext;
  tk_state_t  st_eff;
  tk_state_t  st_n;
  pos_t       tb_n;
  logic       cl;
  logic       cl_n;
  logic       q_n;
  tok_t       e0;
  tok_t       e1;
  tok_t       f;
  logic       f_en;
  logic [1:0] hcnt;
  tok_t       mark;

  always_comb begin
    c      = item.in_byte;
    eoi    = item.end_of_input;
    p      = cur.pos;
    tb     = cur.tb;
    p_ext  = {1'b0, p};
    p1_ext = p_ext + pos_ext_t'(1);
    pn     = (p == '1) ? p : p + pos_t'(1);
    mark   = mk(TK_MARK, p, FldW'(1));

    st_eff = cur.st;
    cl     = cur.closing;
    case (cur.st)
      ST_TAG_OPEN: begin
        if (!(c == CH_BANG || c == CH_SLASH || c == CH_QMARK || is_letter(c))) begin
          st_eff = ST_DATA;
        end
      end
      ST_END_TAG_OPEN: begin
        if (!is_letter(c) && c != CH_GT) begin
          st_eff = ST_DATA;
          cl     = 1'b0;
        end
      end
      ST_SELF_CLOSE: begin
        if (c != CH_GT) begin
          st_eff = ST_BEFORE_ANAME;
        end
      end
      ST_MARKUP_OPEN, ST_MARKUP_DASH: begin
        if (c != CH_DASH) begin
          st_eff = ST_UNSUP;
        end
      end
      default: begin
      end
    endcase

    st_n = st_eff;
    tb_n = tb;
    cl_n = cl;
    q_n  = cur.quote;
    e0   = '0;
    e1   = '0;
    hcnt = 2'd0;
    case (st_eff)
      ST_DATA: begin
        if (c == CH_LT && !eoi) begin
          if (p > tb) begin
            e0   = mk(TK_TEXT, tb, span_len(p_ext, tb));
            hcnt = 2'd1;
          end
          tb_n = p;
          st_n = ST_TAG_OPEN;
        end
      end
      ST_TAG_OPEN: begin
        if (c == CH_BANG) begin
          st_n = ST_MARKUP_OPEN;
        end else if (c == CH_SLASH) begin
          cl_n = 1'b1;
          st_n = ST_END_TAG_OPEN;
        end else if (c == CH_QMARK) begin
          st_n = ST_BOGUS;
          tb_n = pn;
        end else begin
          st_n = ST_TAG_NAME;
          tb_n = p;
        end
      end
      ST_END_TAG_OPEN: begin
        if (is_letter(c)) begin
          st_n = ST_TAG_NAME;
          tb_n = p;
        end else begin
          cl_n = 1'b0;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_TAG_NAME: begin
        if (is_ws(c) || c == CH_SLASH || c == CH_GT) begin
          hcnt = 2'd1;
          if (cl) begin
            e0   = mk(TK_END_TAG, tb, span_len(p_ext, tb));
            cl_n = 1'b0;
            if (c == CH_GT) begin
              st_n = ST_DATA;
              tb_n = pn;
            end else begin
              st_n = ST_END_TAG_SKIP;
            end
          end else begin
            e0 = mk(TK_TAG, tb, span_len(p_ext, tb));
            if (c == CH_GT) begin
              e1   = mark;
              hcnt = 2'd2;
              st_n = ST_DATA;
              tb_n = pn;
            end else begin
              st_n = is_ws(c) ? ST_BEFORE_ANAME : ST_SELF_CLOSE;
            end
          end
        end
      end
      ST_END_TAG_SKIP: begin
        if (c == CH_GT) begin
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_BEFORE_ANAME, ST_AFTER_ANAME, ST_AFTER_VAL_Q: begin
        if (is_ws(c)) begin
          if (st_eff == ST_AFTER_VAL_Q) begin
            st_n = ST_BEFORE_ANAME;
          end
        end else if (c == CH_SLASH) begin
          st_n = ST_SELF_CLOSE;
        end else if (c == CH_GT) begin
          e0   = mark;
          hcnt = 2'd1;
          st_n = ST_DATA;
          tb_n = pn;
        end else if (c == CH_EQ && st_eff == ST_AFTER_ANAME) begin
          st_n = ST_BEFORE_VAL;
        end else begin
          st_n = ST_ANAME;
          tb_n = p;
        end
      end
      ST_ANAME: begin
        if (is_ws(c) || c == CH_SLASH || c == CH_EQ || c == CH_GT) begin
          e0   = mk(TK_ANAME, tb, span_len(p_ext, tb));
          hcnt = 2'd1;
          if (is_ws(c)) begin
            st_n = ST_AFTER_ANAME;
          end else if (c == CH_SLASH) begin
            st_n = ST_SELF_CLOSE;
          end else if (c == CH_EQ) begin
            st_n = ST_BEFORE_VAL;
          end else begin
            e1   = mark;
            hcnt = 2'd2;
            st_n = ST_DATA;
            tb_n = pn;
          end
        end
      end
      ST_BEFORE_VAL: begin
        if (is_ws(c)) begin
          st_n = ST_BEFORE_VAL;
        end else if (c == CH_DQ || c == CH_SQ) begin
          q_n  = (c == CH_SQ);
          st_n = ST_VAL_Q;
          tb_n = pn;
        end else if (c == CH_GT) begin
          e0   = mk(TK_AVAL, p, '0);
          e1   = mark;
          hcnt = 2'd2;
          st_n = ST_DATA;
          tb_n = pn;
        end else begin
          st_n = ST_VAL_UNQ;
          tb_n = p;
        end
      end
      ST_VAL_Q: begin
        if (c == (cur.quote ? CH_SQ : CH_DQ)) begin
          e0   = mk(TK_AVAL, tb, span_len(p_ext, tb));
          hcnt = 2'd1;
          st_n = ST_AFTER_VAL_Q;
        end
      end
      ST_VAL_UNQ: begin
        if (is_ws(c)) begin
          e0   = mk(TK_AVAL, tb, span_len(p_ext, tb));
          hcnt = 2'd1;
          st_n = ST_BEFORE_ANAME;
        end else if (c == CH_GT) begin
          e0   = mk(TK_AVAL, tb, span_len(p_ext, tb));
          e1   = mark;
          hcnt = 2'd2;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_SELF_CLOSE: begin
        if (c == CH_GT) begin
          e0   = mk(TK_SELF, (p != '0) ? p - pos_t'(1) : '0, FldW'(2));
          hcnt = 2'd1;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_MARKUP_OPEN: begin
        st_n = ST_MARKUP_DASH;
      end
      ST_MARKUP_DASH: begin
        st_n = ST_COMMENT;
        tb_n = pn;
      end
      ST_COMMENT: begin
        if (c == CH_GT && p_ext >= ({1'b0, tb} + pos_ext_t'(2)) &&
            (cur.la[7:0] == CH_DASH || cur.la[7:0] == CH_BANG) &&
            cur.la[15:8] == CH_DASH) begin
          e0   = mk(TK_COMMENT, tb, span_len(p_ext - pos_ext_t'(2), tb));
          hcnt = 2'd1;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_BOGUS: begin
        if (c == CH_GT) begin
          e0   = mk(TK_COMMENT, tb, span_len(p_ext, tb));
          hcnt = 2'd1;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      ST_UNSUP: begin
        if (c == CH_GT) begin
          e0   = mk(TK_UNSUP, tb, span_len(p1_ext, tb));
          hcnt = 2'd1;
          st_n = ST_DATA;
          tb_n = pn;
        end
      end
      default: begin
        st_n = ST_DATA;
      end
    endcase

    f    = '0;
    f_en = 1'b0;
    if (eoi) begin
      case (st_n)
        ST_DATA, ST_TAG_OPEN, ST_END_TAG_OPEN: begin
          if (p1_ext > {1'b0, tb_n}) begin
            f    = mk(TK_TEXT, tb_n, span_len(p1_ext, tb_n));
            f_en = 1'b1;
          end
        end
        ST_TAG_NAME: begin
          f    = mk(cl_n ? TK_END_TAG : TK_TAG, tb_n, span_len(p1_ext, tb_n));
          f_en = 1'b1;
        end
        ST_ANAME: begin
          f    = mk(TK_ANAME, tb_n, span_len(p1_ext, tb_n));
          f_en = 1'b1;
        end
        ST_VAL_Q, ST_VAL_UNQ: begin
          f    = mk(TK_AVAL, tb_n, span_len(p1_ext, tb_n));
          f_en = 1'b1;
        end
        ST_COMMENT, ST_BOGUS: begin
          f    = mk(TK_COMMENT, tb_n, span_len(p1_ext, tb_n));
          f_en = 1'b1;
        end
        ST_MARKUP_OPEN, ST_MARKUP_DASH, ST_UNSUP: begin
          f    = mk(TK_UNSUP, tb_n, span_len(p1_ext, tb_n));
          f_en = 1'b1;
        end
        default: begin
        end
      endcase
    end

    bundle        = '0;
    bundle.tok[0] = e0;
    bundle.tok[1] = e1;
    if (f_en) begin
      bundle.tok[hcnt] = f;
    end
    bundle.count = hcnt + {1'b0, f_en};

    if (eoi) begin
      nxt    = '0;
      nxt.st = ST_DATA;
    end else begin
      nxt.st      = st_n;
      nxt.pos     = pn;
      nxt.tb      = tb_n;
      nxt.closing = cl_n;
      nxt.quote   = q_n;
      nxt.la      = {cur.la[7:0], c};
    end
  end

endmodule

// ----- sv/htt_emit.sv -----
// Token result register; a byte's tokens leave one per cycle unless stalled.
module htt_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  htt_pkg::bundle_t bundle_in,
  output logic             ready,
  output logic             token_valid,
  input  logic             token_stall,
  output htt_pkg::token_t  token
);
  import htt_pkg::*;

  tok_t [MaxTok-1:0] slots;
  logic [1:0]        cnt;
  logic [1:0]        idx;
  logic              last;
  logic              out_fire;

  assign token_valid = (cnt != 2'd0);
  assign last        = (idx == cnt - 2'd1);
  assign out_fire    = token_valid && !token_stall;
  assign ready       = (cnt == 2'd0) || (out_fire && last);

  assign token.token_kind   = slots[idx].kind;
  assign token.token_offset = slots[idx].offset;
  assign token.token_length = slots[idx].length;
  assign token.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle_in.count;
      idx <= 2'd0;
    end else if (out_fire) begin
      if (last) begin
        cnt <= 2'd0;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle_in.tok;
    end
  end

endmodule

// ----- sv/html5_tag_tokenizer.sv -----
// HTML tag tokenizer top level: input register, tokenizer state and token output.
// Scans one document byte per cycle unless stalled and reports text, tag,
// attribute, comment and unsupported-markup tokens with offset and length. A byte
// is taken into an input register, then stepped by the tokenizer logic into the
// result register once that is ready. The output port delivers one token per
// cycle while token_stall is low, so a byte that ends k tokens (k up to 3) is
// held until all k are taken; bytes that end at most one token stream at one
// per cycle, and bytes that end none leave no trace on the output. The byte marked
// end of input flushes the open token and restarts the offset count at zero.
module html5_tag_tokenizer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  htt_pkg::item_t  item,
  output logic            token_valid,
  input  logic            token_stall,
  output htt_pkg::token_t token
);
  import htt_pkg::*;

  item_t   item_q;
  logic    in_full;
  logic    in_fire;
  logic    step_fire;
  logic    emit_ready;
  state_t  st;
  state_t  st_next;
  bundle_t bundle;

  assign step_fire  = in_full && emit_ready;
  assign item_stall = in_full && !emit_ready;
  assign in_fire    = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_fire) begin
      in_full <= 1'b1;
    end else if (step_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{st: ST_DATA, pos: '0, tb: '0, closing: 1'b0, quote: 1'b0, la: '0};
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  htt_step u_step (
    .cur    (st),
    .item   (item_q),
    .nxt    (st_next),
    .bundle (bundle)
  );

  htt_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (step_fire),
    .bundle_in   (bundle),
    .ready       (emit_ready),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

endmodule

// ----- tb/tb_html5_tag_tokenizer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the HTML tag tokenizer: byte streams in, predicted tokens checked.
module tb_html5_tag_tokenizer;
  import htt_pkg::*;

  localparam int CycleLimit   = 2000000;
  localparam int DrainLimit   = 20000;
  localparam int SettleCycles = 8;
  localparam int ReportCap    = 100;
  localparam int PosMax       = (1 << OffsetBits) - 1;
  localparam int FldMax       = (1 << FldW) - 1;
  localparam int HoldCycles   = 300;

  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_UC_A = 8'd65;
  localparam logic [7:0] CH_UC_Z = 8'd90;
  localparam logic [7:0] CH_LC_A = 8'd97;
  localparam logic [7:0] CH_LC_Z = 8'd122;

  class token_scoreboard;
    tk_state_t   st;
    int          pos;
    int          tok_start;
    bit          closing;
    bit          quote;
    logic [15:0] la;
    token_t      tokens_due[$];
    token_t      fresh[$];
    int          errors;
    int          checked;
    int          kind_seen[9];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      st        = ST_DATA;
      pos       = 0;
      tok_start = 0;
      closing   = 1'b0;
      quote     = 1'b0;
      la        = '0;
    endfunction

    function int next_pos(int p);
      return (p < PosMax) ? p + 1 : PosMax;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_TAB + 8'd4);
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function void emit_raw(logic [3:0] kind, int off, int len);
      token_t t;
      if (fresh.size() >= MaxTok) return;
      t.token_kind   = kind;
      t.token_offset = off[FldW-1:0];
      if (len > FldMax) t.token_length = '1;
      else t.token_length = len[FldW-1:0];
      t.last_of_run  = 1'b0;
      fresh.push_back(t);
    endfunction

    function void emit_span(logic [3:0] kind, int stop);
      emit_raw(kind, tok_start, (stop > tok_start) ? stop - tok_start : 0);
    endfunction

    function void to_data_after();
      st        = ST_DATA;
      tok_start = next_pos(pos);
    endfunction

    function void end_mark();
      emit_raw(TK_MARK, pos, 1);
      to_data_after();
    endfunction

    // returns 1 when the byte must be taken again in the new state
    function bit advance(logic [7:0] c, bit eoi);
      int p;
      bit redo;
      p    = pos;
      redo = 1'b0;
      case (st)
        ST_DATA: begin
          if (c == CH_LT && !eoi) begin
            if (p > tok_start) emit_span(TK_TEXT, p);
            tok_start = p;
            st        = ST_TAG_OPEN;
          end
        end
        ST_TAG_OPEN: begin
          if (c == CH_BANG) st = ST_MARKUP_OPEN;
          else if (c == CH_SLASH) begin
            closing = 1'b1;
            st      = ST_END_TAG_OPEN;
          end else if (c == CH_QMARK) begin
            st        = ST_BOGUS;
            tok_start = next_pos(p);
          end else if (is_letter(c)) begin
            st        = ST_TAG_NAME;
            tok_start = p;
          end else begin
            st   = ST_DATA;
            redo = 1'b1;
          end
        end
        ST_END_TAG_OPEN: begin
          if (is_letter(c)) begin
            st        = ST_TAG_NAME;
            tok_start = p;
          end else begin
            closing = 1'b0;
            if (c == CH_GT) to_data_after();
            else begin
              st   = ST_DATA;
              redo = 1'b1;
            end
          end
        end
        ST_TAG_NAME: begin
          if (is_ws(c) || c == CH_SLASH || c == CH_GT) begin
            if (closing) begin
              emit_span(TK_END_TAG, p);
              closing = 1'b0;
              if (c == CH_GT) to_data_after();
              else st = ST_END_TAG_SKIP;
            end else begin
              emit_span(TK_TAG, p);
              if (c == CH_GT) end_mark();
              else st = is_ws(c) ? ST_BEFORE_ANAME : ST_SELF_CLOSE;
            end
          end
        end
        ST_END_TAG_SKIP: begin
          if (c == CH_GT) to_data_after();
        end
        ST_BEFORE_ANAME, ST_AFTER_ANAME, ST_AFTER_VAL_Q: begin
          if (is_ws(c)) begin
            if (st == ST_AFTER_VAL_Q) st = ST_BEFORE_ANAME;
          end else if (c == CH_SLASH) st = ST_SELF_CLOSE;
          else if (c == CH_GT) end_mark();
          else if (c == CH_EQ && st == ST_AFTER_ANAME) st = ST_BEFORE_VAL;
          else begin
            st        = ST_ANAME;
            tok_start = p;
          end
        end
        ST_ANAME: begin
          if (is_ws(c) || c == CH_SLASH || c == CH_EQ || c == CH_GT) begin
            emit_span(TK_ANAME, p);
            if (is_ws(c)) st = ST_AFTER_ANAME;
            else if (c == CH_SLASH) st = ST_SELF_CLOSE;
            else if (c == CH_EQ) st = ST_BEFORE_VAL;
            else end_mark();
          end
        end
        ST_BEFORE_VAL: begin
          if (!is_ws(c)) begin
            if (c == CH_DQ || c == CH_SQ) begin
              quote     = (c == CH_SQ);
              st        = ST_VAL_Q;
              tok_start = next_pos(p);
            end else if (c == CH_GT) begin
              emit_raw(TK_AVAL, p, 0);
              end_mark();
            end else begin
              st        = ST_VAL_UNQ;
              tok_start = p;
            end
          end
        end
        ST_VAL_Q: begin
          if (c == (quote ? CH_SQ : CH_DQ)) begin
            emit_span(TK_AVAL, p);
            st = ST_AFTER_VAL_Q;
          end
        end
        ST_VAL_UNQ: begin
          if (is_ws(c)) begin
            emit_span(TK_AVAL, p);
            st = ST_BEFORE_ANAME;
          end else if (c == CH_GT) begin
            emit_span(TK_AVAL, p);
            end_mark();
          end
        end
        ST_SELF_CLOSE: begin
          if (c == CH_GT) begin
            emit_raw(TK_SELF, (p > 0) ? p - 1 : 0, 2);
            to_data_after();
          end else begin
            st   = ST_BEFORE_ANAME;
            redo = 1'b1;
          end
        end
        ST_MARKUP_OPEN, ST_MARKUP_DASH: begin
          if (c != CH_DASH) begin
            st   = ST_UNSUP;
            redo = 1'b1;
          end else if (st == ST_MARKUP_OPEN) st = ST_MARKUP_DASH;
          else begin
            st        = ST_COMMENT;
            tok_start = next_pos(p);
          end
        end
        ST_COMMENT: begin
          if (c == CH_GT && p >= tok_start + 2 && (la[7:0] == CH_DASH || la[7:0] == CH_BANG)
              && la[15:8] == CH_DASH) begin
            emit_span(TK_COMMENT, p - 2);
            to_data_after();
          end
        end
        ST_BOGUS: begin
          if (c == CH_GT) begin
            emit_span(TK_COMMENT, p);
            to_data_after();
          end
        end
        ST_UNSUP: begin
          if (c == CH_GT) begin
            emit_span(TK_UNSUP, p + 1);
            to_data_after();
          end
        end
        default: st = ST_DATA;
      endcase
      return redo;
    endfunction

    function void flush_open();
      int stop;
      stop = pos + 1;
      case (st)
        ST_DATA, ST_TAG_OPEN, ST_END_TAG_OPEN: begin
          if (stop > tok_start) emit_span(TK_TEXT, stop);
        end
        ST_TAG_NAME:                              emit_span(closing ? TK_END_TAG : TK_TAG, stop);
        ST_ANAME:                                 emit_span(TK_ANAME, stop);
        ST_VAL_Q, ST_VAL_UNQ:                     emit_span(TK_AVAL, stop);
        ST_COMMENT, ST_BOGUS:                     emit_span(TK_COMMENT, stop);
        ST_MARKUP_OPEN, ST_MARKUP_DASH, ST_UNSUP: emit_span(TK_UNSUP, stop);
        default: ;
      endcase
    endfunction

    function void note_byte(item_t it);
      logic [7:0] c;
      bit         eoi;
      int         n;
      c   = it.in_byte;
      eoi = it.end_of_input;
      fresh.delete();
      for (int k = 0; k < 3; k++) begin
        if (!advance(c, eoi)) break;
      end
      if (eoi) flush_open();
      la  = {la[7:0], c};
      pos = next_pos(pos);
      if (eoi) clear_state();
      n = fresh.size();
      if (n > 0) fresh[n-1].last_of_run = 1'b1;
      foreach (fresh[k]) tokens_due.push_back(fresh[k]);
    endfunction

    function void mismatch(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= ReportCap) $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= ReportCap)
          $error("token kind %0d offset %0d length %0d arrived with none expected",
                 got.token_kind, got.token_offset, got.token_length);
        return;
      end
      want = tokens_due.pop_front();
      checked++;
      if (want.token_kind <= TK_UNSUP) kind_seen[want.token_kind]++;
      if (got.token_kind !== want.token_kind)
        mismatch("token_kind", want.token_kind, got.token_kind);
      if (got.token_offset !== want.token_offset)
        mismatch("token_offset", want.token_offset, got.token_offset);
      if (got.token_length !== want.token_length)
        mismatch("token_length", want.token_length, got.token_length);
      if (got.last_of_run !== want.last_of_run)
        mismatch("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic   clk;
  logic   rst         = 1'b1;
  logic   item_valid  = 1'b0;
  logic   item_stall;
  item_t  item        = '0;
  logic   token_valid;
  logic   token_stall = 1'b0;
  token_t token;

  token_scoreboard sb;
  bit              calm = 1'b0;
  int              hold_req;
  int              hold_left;
  int              bytes_sent;
  int              docs_sent;
  int              longest_doc;
  int              rand_bytes;
  logic [7:0]      doc[$];
  string           directed = "<i/><!x></b c><a x=></><=<!-->-->";

  html5_tag_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) sb.check_token(token);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      token_stall <= 1'b1;
    end else if (calm || rst) token_stall <= 1'b0;
    else token_stall <= ($urandom_range(99) < 30);
  end

  function automatic void put(logic [7:0] b);
    doc.push_back(b);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(51);
    if (r < 26) return CH_LC_A + r[7:0];
    return CH_UC_A + r[7:0] - 8'd26;
  endfunction

  function automatic logic [7:0] pick_ws();
    int r;
    r = $urandom_range(5);
    if (r == 5) return CH_SP;
    return CH_TAB + r[7:0];
  endfunction

  function automatic logic [7:0] pick_markup();
    int r;
    r = $urandom_range(12);
    case (r)
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_SLASH;
      3:       return CH_BANG;
      4:       return CH_DASH;
      5:       return CH_EQ;
      6:       return CH_DQ;
      7:       return CH_SQ;
      8:       return CH_QMARK;
      9:       return pick_ws();
      10:      return pick_letter();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void add_name();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(7) == 0) put(CH_ZERO + 8'($urandom_range(9)));
      else put(pick_letter());
    end
  endfunction

  function automatic void add_text(int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) put(8'($urandom_range(255)));
      else if ($urandom_range(5) == 0) put(pick_ws());
      else put(pick_letter());
    end
  endfunction

  function automatic void add_quoted(logic [7:0] q);
    int n;
    put(q);
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(5))
        0:       put(pick_ws());
        1:       put(CH_GT);
        2:       put(CH_SLASH);
        3:       put(q == CH_DQ ? CH_SQ : CH_DQ);
        4:       put(CH_EQ);
        default: put(pick_letter());
      endcase
    end
    if ($urandom_range(19) != 0) put(q);
  endfunction

  function automatic void add_fragment(int max_text);
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 25) add_text($urandom_range(1, max_text));
    else if (r < 50) begin
      put(CH_LT);
      add_name();
      n = $urandom_range(0, 3);
      repeat (n) begin
        put(pick_ws());
        if ($urandom_range(3) == 0) put(pick_ws());
        add_name();
        case ($urandom_range(6))
          0: ;
          1: begin
            put(CH_EQ);
            add_quoted(CH_DQ);
          end
          2: begin
            put(CH_EQ);
            add_quoted(CH_SQ);
          end
          3: begin
            put(CH_EQ);
            add_name();
          end
          4: begin
            put(pick_ws());
            put(CH_EQ);
            put(pick_ws());
            add_quoted(CH_DQ);
          end
          5: put(CH_EQ);
          default: put(pick_ws());
        endcase
      end
      case ($urandom_range(9))
        6, 7: begin
          put(CH_SLASH);
          put(CH_GT);
        end
        8: begin
          put(pick_ws());
          put(CH_SLASH);
          put(CH_GT);
        end
        9: ;
        default: put(CH_GT);
      endcase
    end else if (r < 62) begin
      put(CH_LT);
      put(CH_SLASH);
      case ($urandom_range(7))
        0: put(CH_GT);
        1: put(CH_ZERO);
        2, 3: begin
          add_name();
          put(pick_ws());
          n = $urandom_range(0, 3);
          repeat (n) put(pick_markup());
          put(CH_GT);
        end
        default: begin
          add_name();
          put(CH_GT);
        end
      endcase
    end else if (r < 74) begin
      put(CH_LT);
      put(CH_BANG);
      put(CH_DASH);
      put(CH_DASH);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(4))
          0:       put(CH_DASH);
          1:       put(CH_BANG);
          2:       put(CH_GT);
          3:       put(pick_ws());
          default: put(pick_letter());
        endcase
      end
      case ($urandom_range(5))
        3, 4: begin
          put(CH_DASH);
          put(CH_BANG);
          put(CH_GT);
        end
        5: ;
        default: begin
          put(CH_DASH);
          put(CH_DASH);
          put(CH_GT);
        end
      endcase
    end else if (r < 80) begin
      put(CH_LT);
      put(CH_QMARK);
      add_text($urandom_range(0, 4));
      put(CH_GT);
    end else if (r < 86) begin
      put(CH_LT);
      put(CH_BANG);
      if ($urandom_range(3) == 0) put(CH_DASH);
      put(pick_letter());
      n = $urandom_range(0, 4);
      repeat (n) put(($urandom_range(2) == 0) ? pick_ws() : pick_letter());
      put(CH_GT);
    end else if (r < 94) begin
      n = $urandom_range(1, 4);
      repeat (n) put(pick_markup());
    end else begin
      put(CH_LT);
      case ($urandom_range(3))
        0: put(pick_letter());
        1: put(CH_BANG);
        2: put(CH_SLASH);
        default: ;
      endcase
    end
  endfunction

  function automatic void build_doc();
    int n;
    n = $urandom_range(1, 5);
    repeat (n) add_fragment(6);
    rand_bytes += doc.size();
  endfunction

  task automatic send_item(input item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_doc();
    item_t it;
    for (int i = 0; i < doc.size(); i++) begin
      it.in_byte      = doc[i];
      it.end_of_input = (i == doc.size() - 1);
      send_item(it);
    end
    if (doc.size() > longest_doc) longest_doc = doc.size();
    docs_sent++;
    doc.delete();
  endtask

  task automatic wait_for_drain();
    int waited;
    waited = 0;
    item_valid <= 1'b0;
    while (sb.tokens_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(8'hFF);
    for (int i = 0; i < directed.len(); i++) put(directed[i]);
    put(8'h00);
    put(CH_LT);
    send_doc();
    wait_for_drain();

    while (rand_bytes < 30) begin
      build_doc();
      send_doc();
    end

    calm = 1'b1;
    while (rand_bytes < 60) begin
      build_doc();
      send_doc();
    end
    calm = 1'b0;

    // hold the token side while requests keep coming
    hold_req = HoldCycles;
    repeat (6) add_fragment(6);
    send_doc();
    wait_for_drain();

    while (rand_bytes < 90) begin
      build_doc();
      send_doc();
      if (docs_sent % 4 == 0) wait_for_drain();
    end
    wait_for_drain();

    if (sb.tokens_due.size() != 0) begin
      $error("%0d expected tokens never arrived", sb.tokens_due.size());
      sb.errors++;
    end

    $display("Run covered %0d bytes in %0d documents, longest %0d bytes, with random stalls",
             bytes_sent, docs_sent, longest_doc);
    $display("Tokens %0d by kind %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             sb.checked, sb.kind_seen[TK_TEXT], sb.kind_seen[TK_TAG], sb.kind_seen[TK_MARK],
             sb.kind_seen[TK_SELF], sb.kind_seen[TK_END_TAG], sb.kind_seen[TK_ANAME],
             sb.kind_seen[TK_AVAL], sb.kind_seen[TK_COMMENT], sb.kind_seen[TK_UNSUP]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
